// ===== sv/frmq_pkg.sv =====
// Shared types, codes and constants for the frame queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package frmq_pkg;

    // default sizes of the top level
    localparam int DEF_QUEUE_DEPTH  = 32;
    localparam int DEF_TIME_BITS    = 48;
    localparam int DEF_PAYLOAD_BITS = 32;

    // fixed register and counter widths
    localparam int LIMIT_W    = 6;
    localparam int POLICY_W   = 2;
    localparam int GAP_W      = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int MODE_W     = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(30);
    localparam logic [GAP_W-1:0]   GAP_RESET   = GAP_W'(100000);

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [POLICY_W-1:0] {
        POL_DROP_OLDEST = 2'd0,
        POL_DROP_NEWEST = 2'd1,
        POL_DROP_NONKEY = 2'd2,
        POL_BLOCK       = 2'd3
    } t_policy;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUEUE_LIMIT = 2'd0,
        REG_DROP_POLICY = 2'd1,
        REG_SYNC_ENABLE = 2'd2,
        REG_MAX_GAP     = 2'd3
    } t_cfg_reg;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the incoming operation
        logic commit;   // execute it and load the result register
    } t_dp_cmd;

    // round a bit count up to whole bytes
    function automatic int pad8(input int n);
        return ((n + 7) >> 3) << 3;
    endfunction

endpackage

`default_nettype wire

// ===== sv/frmq_ctrl.sv =====
// Controller of the frame queue: operation sequencing and output valid.
// Depends on frmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frmq_ctrl
    import frmq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_s_tready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            ST_EXEC: begin
                o_cmd.commit = slot_free;
            end
        endcase
        n_out_valid = o_cmd.commit || (r_out_valid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/frmq_dp.sv =====
// Datapath of the frame queue: shift-cell entry store, drop policy,
// gap check, counters, configuration registers and result register.
// Depends on frmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frmq_dp
    import frmq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS    = DEF_TIME_BITS,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  wire t_dp_cmd                       i_cmd,
    input  wire logic [MODE_W-1:0]             i_mode,
    input  wire logic [TIME_BITS-1:0]          i_ts,
    input  wire logic                          i_key,
    input  wire logic [PAYLOAD_BITS-1:0]       i_pay,
    output logic                               o_ok,
    output logic [TIME_BITS-1:0]               o_ts,
    output logic                               o_key,
    output logic [PAYLOAD_BITS-1:0]            o_pay,
    output logic                               o_drop,
    output logic                               o_warn,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_fill,
    output logic [CNT_W-1:0]                   o_pushed,
    output logic [CNT_W-1:0]                   o_popped,
    output logic [CNT_W-1:0]                   o_dropped
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;
    localparam int GW = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;

    // configuration
    logic [LIMIT_W-1:0] r_limit;
    t_policy            r_policy;
    logic               r_sync_en;
    logic [GAP_W-1:0]   r_gap;

    // latched operation
    t_op                     r_mode;
    logic [TIME_BITS-1:0]    r_ts;
    logic                    r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;

    // entry cells, front at index 0
    logic [TIME_BITS-1:0]    r_cell_ts  [QUEUE_DEPTH];
    logic                    r_cell_key [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] r_cell_pay [QUEUE_DEPTH];

    logic [LW-1:0]        r_held;
    logic [TIME_BITS-1:0] r_newest;  // timestamp of the last entry
    logic [TIME_BITS-1:0] r_prev;    // timestamp of the entry before it
    logic [CNT_W-1:0]     r_pushed;
    logic [CNT_W-1:0]     r_popped;
    logic [CNT_W-1:0]     r_dropped;

    logic                    r_ok;
    logic [TIME_BITS-1:0]    r_out_ts;
    logic                    r_out_key;
    logic [PAYLOAD_BITS-1:0] r_out_pay;
    logic                    r_drop;
    logic                    r_warn;

    logic [LW-1:0]          eff_limit;
    logic                   is_push;
    logic                   is_read;
    logic                   full;
    logic                   has_front;
    logic [QUEUE_DEPTH-1:0] nonkey;
    logic                   any_nonkey;
    logic [IW-1:0]          nk_pos;
    logic [IW-1:0]          rm_pos;
    logic                   evict;
    logic                   refuse;
    logic                   count_drop;
    logic                   pop_rm;
    logic [QUEUE_DEPTH-1:0] shift;
    logic [QUEUE_DEPTH-1:0] wr;
    logic [LW-1:0]          held_mid;
    logic                   last_removed;
    logic [TIME_BITS-1:0]   last_ts;
    logic [TIME_BITS-1:0]   diff;
    logic                   warn;
    logic                   store;
    logic [LW-1:0]          n_held;

    // limit clamped to 1..QUEUE_DEPTH
    always_comb begin
        if (r_limit == '0) begin
            eff_limit = LW'(1);
        end else if (CW'(r_limit) > CW'(QUEUE_DEPTH)) begin
            eff_limit = LW'(QUEUE_DEPTH);
        end else begin
            eff_limit = LW'(r_limit);
        end
    end

    // oldest non-keyframe among the held entries
    always_comb begin
        nk_pos = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            nonkey[i] = !r_cell_key[i] && (LW'(i) < r_held);
        end
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (nonkey[i]) begin
                nk_pos = IW'(i);
            end
        end
        any_nonkey = |nonkey;
    end

    always_comb begin
        is_push    = (r_mode == OP_PUSH);
        is_read    = (r_mode == OP_POP) || (r_mode == OP_PEEK);
        has_front  = (r_held != '0);
        full       = (r_held >= eff_limit);
        evict      = is_push && full &&
                     ((r_policy == POL_DROP_OLDEST) || (r_policy == POL_DROP_NONKEY));
        refuse     = is_push && full &&
                     ((r_policy == POL_DROP_NEWEST) || (r_policy == POL_BLOCK));
        count_drop = is_push && full && (r_policy != POL_BLOCK);
        pop_rm     = (r_mode == OP_POP) && has_front;

        // removal point: front unless a non-keyframe is found
        rm_pos = (r_policy == POL_DROP_NONKEY && any_nonkey) ? nk_pos : '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            shift[i] = pop_rm || (evict && (IW'(i) >= rm_pos));
        end
        held_mid = r_held - LW'(evict || pop_rm);

        // the newest entry went away: compare against the one before it
        last_removed = evict && (LW'(rm_pos) == r_held - LW'(1));
        last_ts      = last_removed ? r_prev : r_newest;
        diff         = (r_ts >= last_ts) ? (r_ts - last_ts) : (last_ts - r_ts);
        warn         = is_push && r_sync_en && (held_mid != '0) && (GW'(diff) > GW'(r_gap));

        store = is_push && !refuse && (held_mid < LW'(QUEUE_DEPTH));
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            wr[i] = store && (LW'(i) == held_mid);
        end

        if (r_mode == OP_CLEAR) begin
            n_held = '0;
        end else begin
            n_held = held_mid + LW'(store);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_policy  <= POL_DROP_OLDEST;
            r_sync_en <= 1'b1;
            r_gap     <= GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_QUEUE_LIMIT: r_limit   <= i_cfg_data[LIMIT_W-1:0];
                REG_DROP_POLICY: r_policy  <= t_policy'(i_cfg_data[POLICY_W-1:0]);
                REG_SYNC_ENABLE: r_sync_en <= i_cfg_data[0];
                REG_MAX_GAP:     r_gap     <= i_cfg_data[GAP_W-1:0];
            endcase
        end
    end

    // control state: fill count and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_pushed  <= '0;
            r_popped  <= '0;
            r_dropped <= '0;
        end else if (i_cmd.commit) begin
            r_held    <= n_held;
            r_pushed  <= r_pushed + CNT_W'(store);
            r_popped  <= r_popped + CNT_W'(pop_rm);
            r_dropped <= r_dropped + CNT_W'(count_drop);
        end
    end

    // payload: latched operation, cells, newest stamps, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= t_op'(i_mode);
            r_ts   <= i_ts;
            r_key  <= i_key;
            r_pay  <= i_pay;
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (wr[i]) begin
                    r_cell_ts[i]  <= r_ts;
                    r_cell_key[i] <= r_key;
                    r_cell_pay[i] <= r_pay;
                end else if (shift[i] && (i < QUEUE_DEPTH - 1)) begin
                    r_cell_ts[i]  <= r_cell_ts[(i + 1) % QUEUE_DEPTH];
                    r_cell_key[i] <= r_cell_key[(i + 1) % QUEUE_DEPTH];
                    r_cell_pay[i] <= r_cell_pay[(i + 1) % QUEUE_DEPTH];
                end
            end
            if (store) begin
                r_prev   <= last_ts;
                r_newest <= r_ts;
            end
            r_ok      <= store || (is_read && has_front);
            r_out_ts  <= (is_read && has_front) ? r_cell_ts[0]  : '0;
            r_out_key <= is_read && has_front && r_cell_key[0];
            r_out_pay <= (is_read && has_front) ? r_cell_pay[0] : '0;
            r_drop    <= count_drop;
            r_warn    <= warn;
        end
    end

    assign o_ok      = r_ok;
    assign o_ts      = r_out_ts;
    assign o_key     = r_out_key;
    assign o_pay     = r_out_pay;
    assign o_drop    = r_drop;
    assign o_warn    = r_warn;
    assign o_fill    = r_held;
    assign o_pushed  = r_pushed;
    assign o_popped  = r_popped;
    assign o_dropped = r_dropped;

endmodule

`default_nettype wire

// ===== sv/frame_queue_with_drop_policy.sv =====
// Top level of the bounded frame queue with drop policy.
// Depends on frmq_pkg, frmq_ctrl and frmq_dp.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake               carries
//  s (in)    in         i_s_tvalid/o_s_tready   operation (tuser) and frame (tdata)
//  m (out)   out        o_m_tvalid/i_m_tready   status, frame and totals (tdata)
//  cfg       in         i_cfg_we                register index and write data
//
//  Each operation is taken in ST_IDLE and then executed in ST_EXEC against
//  the shift cells (find the oldest non-keyframe, close up, append).
//  The execute state holds while the result register is full and not taken;
//  a new transfer is taken while an earlier result still waits downstream.
//  Reset (synchronous, active low) empties the queue, zeroes the totals and
//  loads the register defaults; the entry cells themselves are not cleared.

module frame_queue_with_drop_policy
    import frmq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS    = DEF_TIME_BITS,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write port
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    // operation stream
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    // tdata from bit 0: in_timestamp, in_keyframe, in_payload, zero fill
    input  wire logic [pad8(TIME_BITS + 1 + PAYLOAD_BITS)-1:0] i_s_tdata,
    // tuser: mode
    input  wire logic [MODE_W-1:0]          i_s_tuser,
    // result stream
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    // tdata from bit 0: ok, out_timestamp, out_keyframe, out_payload,
    // drop_happened, gap_warning, fill_level, pushed_count, popped_count,
    // dropped_count, zero fill
    output logic [pad8(TIME_BITS + PAYLOAD_BITS + 4 + $clog2(QUEUE_DEPTH + 1)
                       + 3 * CNT_W)-1:0]    o_m_tdata
);

    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W = TIME_BITS + PAYLOAD_BITS + 4 + LW + 3 * CNT_W;
    localparam int OUT_DW = pad8(OUT_W);

    t_dp_cmd                 cmd;
    logic                    res_ok;
    logic [TIME_BITS-1:0]    res_ts;
    logic                    res_key;
    logic [PAYLOAD_BITS-1:0] res_pay;
    logic                    res_drop;
    logic                    res_warn;
    logic [LW-1:0]           res_fill;
    logic [CNT_W-1:0]        res_pushed;
    logic [CNT_W-1:0]        res_popped;
    logic [CNT_W-1:0]        res_dropped;
    logic [OUT_W-1:0]        res_packed;

    // sequence each transfer: take it, execute once the result slot is free
    frmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // queue cells, policy logic, totals and registers
    frmq_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TIME_BITS    (TIME_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .i_mode     (i_s_tuser),
        .i_ts       (i_s_tdata[TIME_BITS-1:0]),
        .i_key      (i_s_tdata[TIME_BITS]),
        .i_pay      (i_s_tdata[TIME_BITS+1 +: PAYLOAD_BITS]),
        .o_ok       (res_ok),
        .o_ts       (res_ts),
        .o_key      (res_key),
        .o_pay      (res_pay),
        .o_drop     (res_drop),
        .o_warn     (res_warn),
        .o_fill     (res_fill),
        .o_pushed   (res_pushed),
        .o_popped   (res_popped),
        .o_dropped  (res_dropped)
    );

    // pack the result, first field lowest, zero fill to whole bytes
    assign res_packed = {res_dropped, res_popped, res_pushed, res_fill, res_warn,
                         res_drop, res_pay, res_key, res_ts, res_ok};
    assign o_m_tdata  = OUT_DW'(res_packed);

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for frame_queue_with_drop_policy: directed and random operation
// streams are checked against a behavioral copy of the queue. Depends on frmq_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import frmq_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up
    localparam int DRAIN       = 4;     // covers the execute state plus margin

    localparam logic [47:0] TS_MAX = 48'hFFFF_FFFF_FFFF;

    // one operation as it travels on the slave side
    typedef struct packed {
        t_op         mode;
        logic [47:0] ts;
        logic        key;
        logic [31:0] pay;
    } t_frame_op;

    // result layout, lowest field last
    typedef struct packed {
        logic [5:0]  zero_fill;
        logic [31:0] dropped;
        logic [31:0] popped;
        logic [31:0] pushed;
        logic [5:0]  fill;
        logic        warn;
        logic        drop;
        logic [31:0] pay;
        logic        key;
        logic [47:0] ts;
        logic        ok;
    } t_frame_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    t_cfg_reg          cfg_idx = REG_QUEUE_LIMIT;
    logic [31:0]       cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    // from bit 0: in_timestamp, in_keyframe, in_payload, zero fill
    logic [87:0]       s_word = '0;
    // mode
    t_op               s_mode = OP_PUSH;
    logic              m_valid;
    logic              m_ready = 1'b0;
    // from bit 0: ok, out_timestamp, out_keyframe, out_payload, drop_happened,
    // gap_warning, fill_level, pushed_count, popped_count, dropped_count, zero fill
    logic [191:0]      m_word;

    frame_queue_with_drop_policy dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_word),
        .i_s_tuser  (s_mode),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral queue: shift cells, totals and a shadow of the registers
    // ------------------------------------------------------------------
    logic [47:0] cell_ts  [DEPTH];
    logic        cell_key [DEPTH];
    logic [31:0] cell_pay [DEPTH];
    int          held = 0;
    logic [31:0] stored_n = '0;
    logic [31:0] popped_n = '0;
    logic [31:0] dropped_n = '0;

    logic [5:0]  shadow_limit = LIMIT_RESET;
    t_policy     shadow_policy = POL_DROP_OLDEST;
    logic        shadow_sync = 1'b1;
    logic [31:0] shadow_gap = GAP_RESET;

    t_frame_op     pending_ops[$];    // operations not yet offered to the block
    t_frame_status results_due[$];    // predicted results, oldest first
    t_frame_op     cur_op;
    logic [47:0]   recent_ts = '0;
    logic          calm = 1'b0;       // no idling on either side
    int            send_gap = 0;
    int            recv_gap = 0;
    int            fail_count = 0;
    int            idle_cycles = 0;

    // Append an operation behind the pending ones.
    function automatic void enqueue_op(t_frame_op op);
        pending_ops.insert(pending_ops.size(), op);
    endfunction

    // Take the oldest pending operation.
    function automatic t_frame_op dequeue_op();
        t_frame_op op;
        op = pending_ops[0];
        pending_ops.delete(0);
        return op;
    endfunction

    // Append a predicted result behind the outstanding ones.
    function automatic void expect_status(t_frame_status st);
        results_due.insert(results_due.size(), st);
    endfunction

    // Take the oldest predicted result.
    function automatic t_frame_status next_expected();
        t_frame_status st;
        st = results_due[0];
        results_due.delete(0);
        return st;
    endfunction

    // Remove cell pos and close up the cells behind it.
    function automatic void close_up(int pos);
        for (int i = pos; i < held - 1; i++) begin
            cell_ts[i]  = cell_ts[i + 1];
            cell_key[i] = cell_key[i + 1];
            cell_pay[i] = cell_pay[i + 1];
        end
        held--;
    endfunction

    // Apply one operation to the queue copy and return what the block must report.
    function automatic t_frame_status apply_frame_op(t_frame_op op);
        t_frame_status r;
        int            lim;
        int            victim;
        logic          take;
        logic [47:0]   newest;
        logic [47:0]   diff;
        r = '0;
        case (op.mode)
            OP_PUSH: begin
                take = 1'b1;
                lim = (shadow_limit == 0) ? 1
                    : (shadow_limit > DEPTH ? DEPTH : shadow_limit);
                if (held >= lim) begin
                    case (shadow_policy)
                        POL_DROP_OLDEST: begin
                            close_up(0);
                            dropped_n++;
                            r.drop = 1'b1;
                        end
                        POL_DROP_NEWEST: begin
                            take = 1'b0;
                            dropped_n++;
                            r.drop = 1'b1;
                        end
                        POL_DROP_NONKEY: begin
                            // oldest non-keyframe, or the front when all are keyframes
                            victim = 0;
                            for (int i = held - 1; i >= 0; i--)
                                if (!cell_key[i]) victim = i;
                            close_up(victim);
                            dropped_n++;
                            r.drop = 1'b1;
                        end
                        default: take = 1'b0;
                    endcase
                end
                // gap check runs after any drop, refused pushes included
                if (shadow_sync && held > 0) begin
                    newest = cell_ts[held - 1];
                    diff = (op.ts >= newest) ? op.ts - newest : newest - op.ts;
                    r.warn = (diff > {16'd0, shadow_gap});
                end
                if (take && held < DEPTH) begin
                    cell_ts[held]  = op.ts;
                    cell_key[held] = op.key;
                    cell_pay[held] = op.pay;
                    held++;
                    stored_n++;
                    r.ok = 1'b1;
                end
            end
            OP_POP, OP_PEEK: begin
                if (held > 0) begin
                    r.ok  = 1'b1;
                    r.ts  = cell_ts[0];
                    r.key = cell_key[0];
                    r.pay = cell_pay[0];
                    if (op.mode == OP_POP) begin
                        close_up(0);
                        popped_n++;
                    end
                end
            end
            default: held = 0;  // clear keeps the totals
        endcase
        r.fill    = 6'(held);
        r.pushed  = stored_n;
        r.popped  = popped_n;
        r.dropped = dropped_n;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_field(string name, logic [63:0] want, logic [63:0] seen);
        if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t mismatch on %s: expected %0h, got %0h",
                         $realtime, name, want, seen);
        end
    endtask

    task automatic check_status(t_frame_status got);
        t_frame_status want;
        if (results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t result transfer with nothing outstanding", $realtime);
        end else begin
            want = next_expected();
            note_field("ok",            want.ok,      got.ok);
            note_field("out_timestamp", want.ts,      got.ts);
            note_field("out_keyframe",  want.key,     got.key);
            note_field("out_payload",   want.pay,     got.pay);
            note_field("drop_happened", want.drop,    got.drop);
            note_field("gap_warning",   want.warn,    got.warn);
            note_field("fill_level",    want.fill,    got.fill);
            note_field("pushed_count",  want.pushed,  got.pushed);
            note_field("popped_count",  want.popped,  got.popped);
            note_field("dropped_count", want.dropped, got.dropped);
            note_field("zero fill",     want.zero_fill, got.zero_fill);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending operations, with idle bursts between transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            // predict at the edge that moves the transfer
            if (s_valid && s_ready)
                expect_status(apply_frame_op(cur_op));
            // valid is held until taken, so idling only starts between transfers
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(0, 5);
                    s_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    cur_op = dequeue_op();
                    s_valid <= 1'b1;
                    s_mode  <= cur_op.mode;
                    s_word  <= {7'd0, cur_op.pay, cur_op.key, cur_op.ts};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take results, stalling in bursts
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_status(t_frame_status'(m_word));
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                recv_gap = $urandom_range(0, 5);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // count cycles in which neither side moves a transfer
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Timestamps: mostly close to the previous one so the gap check sees both
    // outcomes, some fully random, a few at the ends of the range.
    function automatic logic [47:0] next_stamp();
        logic [31:0] hi;
        logic [31:0] lo;
        logic [47:0] delta;
        hi = $urandom;
        lo = $urandom;
        delta = 48'($urandom_range(0, 250000));
        case ($urandom_range(0, 9))
            0:       next_stamp = $urandom_range(0, 1) ? TS_MAX : '0;
            1, 2:    next_stamp = {hi[15:0], lo};
            default: next_stamp = $urandom_range(0, 1) ? recent_ts + delta : recent_ts - delta;
        endcase
        recent_ts = next_stamp;
    endfunction

    function automatic t_frame_op make_op(int clear_pct, int push_pct, int key_pct);
        t_frame_op op;
        int        pick;
        pick   = $urandom_range(0, 99);
        op.ts  = next_stamp();
        op.key = ($urandom_range(0, 99) < key_pct);
        op.pay = $urandom;
        if (pick < clear_pct)
            op.mode = OP_CLEAR;
        else if (pick < clear_pct + push_pct)
            op.mode = OP_PUSH;
        else if (pick < clear_pct + push_pct + (100 - clear_pct - push_pct) * 2 / 3)
            op.mode = OP_POP;
        else
            op.mode = OP_PEEK;
        return op;
    endfunction

    task automatic add_op(t_op mode, logic [47:0] ts, logic key, logic [31:0] pay);
        t_frame_op op;
        op.mode = mode;
        op.ts   = ts;
        op.key  = key;
        op.pay  = pay;
        enqueue_op(op);
    endtask

    // Hold the sender until every expected result is back, then let the
    // execute stage empty before touching a register.
    task automatic settle();
        while (pending_ops.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            REG_QUEUE_LIMIT: shadow_limit  = value[5:0];
            REG_DROP_POLICY: shadow_policy = t_policy'(value[1:0]);
            REG_SYNC_ENABLE: shadow_sync   = value[0];
            default:         shadow_gap    = value;
        endcase
    endtask

    task automatic program_queue(logic [5:0] lim, t_policy pol, logic sync, logic [31:0] gap);
        settle();
        write_reg(REG_QUEUE_LIMIT, 32'(lim));
        write_reg(REG_DROP_POLICY, 32'(pol));
        write_reg(REG_SYNC_ENABLE, 32'(sync));
        write_reg(REG_MAX_GAP, gap);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [5:0] lim, t_policy pol, logic sync, logic [31:0] gap,
                             int n, int clear_pct, int push_pct, int key_pct);
        program_queue(lim, pol, sync, gap);
        repeat (n) enqueue_op(make_op(clear_pct, push_pct, key_pct));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: empty-queue pop, peek and clear, extreme frames,
        // the gap check exactly at and just past the allowed gap.
        add_op(OP_POP,   48'd7, 1'b1, 32'h1234_5678);
        add_op(OP_PEEK,  TS_MAX, 1'b0, 32'hFFFF_FFFF);
        add_op(OP_CLEAR, 48'd0, 1'b0, 32'd0);
        add_op(OP_PUSH,  48'd0, 1'b0, 32'd0);
        add_op(OP_PUSH,  TS_MAX, 1'b1, 32'hFFFF_FFFF);
        add_op(OP_PUSH,  TS_MAX - 48'd100000, 1'b0, 32'hA5A5_A5A5);
        add_op(OP_PUSH,  TS_MAX - 48'd200001, 1'b1, 32'h0000_0001);
        add_op(OP_PEEK,  48'd0, 1'b0, 32'd0);
        add_op(OP_POP,   48'd0, 1'b0, 32'd0);
        add_op(OP_POP,   48'd0, 1'b0, 32'd0);
        add_op(OP_CLEAR, TS_MAX, 1'b1, 32'hFFFF_FFFF);
        add_op(OP_PUSH,  48'd5, 1'b0, 32'h5A5A_5A5A);

        // limit zero acts as one; drop newest refuses and counts; zero gap
        program_queue(6'd0, POL_DROP_NEWEST, 1'b1, 32'd0);
        add_op(OP_PUSH, 48'd10, 1'b1, 32'h0000_00AA);
        add_op(OP_PUSH, 48'd10, 1'b0, 32'h0000_00BB);
        add_op(OP_PUSH, 48'd11, 1'b0, 32'h0000_00CC);
        add_op(OP_POP,  48'd0, 1'b0, 32'd0);

        // non-keyframe policy: all keyframes drops the front, else the oldest non-key
        program_queue(6'd2, POL_DROP_NONKEY, 1'b0, 32'hFFFF_FFFF);
        add_op(OP_PUSH, 48'd1, 1'b1, 32'd1);
        add_op(OP_PUSH, 48'd2, 1'b1, 32'd2);
        add_op(OP_PUSH, 48'd3, 1'b0, 32'd3);
        add_op(OP_PUSH, 48'd4, 1'b1, 32'd4);
        add_op(OP_PEEK, 48'd0, 1'b0, 32'd0);
        add_op(OP_POP,  48'd0, 1'b0, 32'd0);
        add_op(OP_POP,  48'd0, 1'b0, 32'd0);

        // block refuses without counting; gap check still runs on the refusal
        program_queue(6'd1, POL_BLOCK, 1'b1, 32'hFFFF_FFFF);
        add_op(OP_PUSH, TS_MAX, 1'b1, 32'hDEAD_0001);
        add_op(OP_PUSH, 48'd0, 1'b0, 32'hDEAD_0002);
        add_op(OP_POP,  48'd0, 1'b0, 32'd0);

        // random phases across limits, policies and gap settings
        run_phase(6'd1,  POL_DROP_NEWEST, 1'b1, 32'd0,          110, 3, 55, 50);
        run_phase(6'd0,  POL_DROP_OLDEST, 1'b1, 32'd1000,       100, 3, 55, 50);
        run_phase(6'd4,  POL_DROP_NONKEY, 1'b1, 32'd100000,     150, 4, 55, 50);
        run_phase(6'd3,  POL_DROP_NONKEY, 1'b0, 32'd0,          100, 4, 60, 100);
        run_phase(6'd32, POL_BLOCK,       1'b1, 32'hFFFF_FFFF,  150, 1, 62, 30);
        run_phase(6'd63, POL_DROP_OLDEST, 1'b1, 32'd50000,      150, 1, 62, 50);
        run_phase(6'd40, POL_DROP_NONKEY, 1'b1, 32'd150000,     150, 1, 62, 80);
        // entered with a deep queue: lower the limit below the fill level
        run_phase(6'd8,  POL_DROP_NEWEST, 1'b0, 32'd100000,     150, 2, 50, 50);
        run_phase(6'd16, POL_BLOCK,       1'b1, 32'd200000,     150, 2, 55, 50);

        // last stretch runs at full rate on both sides
        settle();
        calm = 1'b1;
        run_phase(6'd30, POL_DROP_OLDEST, 1'b1, 32'd100000,     220, 3, 55, 50);

        settle();
        repeat (10) @(posedge i_clk);
        fail_count += results_due.size();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
